// ----- src/ldcr_pkg.sv -----
// Shared types, constants and reciprocal tables for the laser dot centroid ranger.
// Used by every module of the block; has no dependencies of its own.
package ldcr_pkg;

    localparam int COL_W     = 10;
    localparam int ROW_W     = 10;
    localparam int PIX_W     = 8;
    localparam int CNT_W     = 20;
    localparam int SUM_W     = 30;
    localparam int LEFT_W    = 10;
    localparam int CROP_W    = 11;
    localparam int COEF_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int HSV_SHIFT = 12;

    // reciprocal table widths: round(255*4096/v) and round(30*4096/d)
    localparam int RS_W = 20;
    localparam int RH_W = 17;

    // range divider: |num*65536| over |den|
    localparam int PROD_W = 43;
    localparam int NUM_W  = 44;
    localparam int DEN_W  = 34;
    localparam int DVD_W  = 60;
    localparam int ITER_W = 6;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // red test limits
    localparam logic [16:0] SAT_LO = 17'd50;
    localparam logic [16:0] SAT_HI = 17'd250;
    localparam logic [7:0]  VAL_LO = 8'd50;
    localparam logic [7:0]  VAL_HI = 8'd250;
    localparam logic [7:0]  HUE1_LO = 8'd1;
    localparam logic [7:0]  HUE1_HI = 8'd15;
    localparam logic [7:0]  HUE2_LO = 8'd165;
    localparam logic [7:0]  HUE2_HI = 8'd179;
    localparam logic [7:0]  HUE_WRAP = 8'd180;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CROP_LEFT    = 3'd0,
        REG_CROP_WIDTH   = 3'd1,
        REG_CROP_ROWS    = 3'd2,
        REG_COEFF_OFFSET = 3'd3,
        REG_COEFF_SLOPE  = 3'd4,
        REG_COEFF_SHIFT  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIV_COL,
        DIV_ROW,
        DIV_RNG
    } t_div_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_DIV_COL,
        ST_WAIT_COL,
        ST_DIV_ROW,
        ST_WAIT_ROW,
        ST_MUL,
        ST_NUM,
        ST_CHK,
        ST_DIV_RNG,
        ST_WAIT_RNG,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       div_start;
        t_div_sel   div_sel;
        logic       mul_en;
        logic       num_en;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic div_done;
        logic found;
        logic den_zero;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [LEFT_W-1:0] crop_left;
        logic [CROP_W-1:0] crop_width;
        logic [CROP_W-1:0] crop_rows;
        logic [COEF_W-1:0] coeff_offset;
        logic [COEF_W-1:0] coeff_slope;
        logic [COEF_W-1:0] coeff_shift;
    } t_cfg;

    // round((num << 12) / d) by long division, evaluated at elaboration
    function automatic logic [RS_W-1:0] recip_round(input int unsigned num,
                                                    input int unsigned d);
        logic [23:0] n;
        logic [23:0] dv;
        logic [24:0] rem;
        logic [23:0] q;
        n   = 24'((num << (HSV_SHIFT + 1)) + d);
        dv  = 24'(2 * d);
        rem = '0;
        q   = '0;
        for (int i = 23; i >= 0; i--) begin
            rem = {rem[23:0], n[i]};
            if (rem >= {1'b0, dv}) begin
                rem  = rem - {1'b0, dv};
                q[i] = 1'b1;
            end
        end
        if (d == 0) begin
            q = '0;
        end
        return q[RS_W-1:0];
    endfunction

    typedef logic [RS_W-1:0] t_rs_tab [256];
    typedef logic [RH_W-1:0] t_rh_tab [256];

    function automatic t_rs_tab mk_sat_tab();
        t_rs_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = recip_round(255, i);
        end
        return tab;
    endfunction

    function automatic t_rh_tab mk_hue_tab();
        t_rh_tab         tab;
        logic [RS_W-1:0] tmp;
        for (int i = 0; i < 256; i++) begin
            tmp    = recip_round(30, i);
            tab[i] = tmp[RH_W-1:0];
        end
        return tab;
    endfunction

    localparam t_rs_tab RECIP_SAT = mk_sat_tab();
    localparam t_rh_tab RECIP_HUE = mk_hue_tab();

endpackage

// ----- src/ldcr_pix.sv -----
// Pixel pipeline: crop window test, BGR to HSV conversion and red test.
// Four register stages; depends on ldcr_pkg for tables and limits.
module ldcr_pix import ldcr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [COL_W-1:0] i_col,
    input  logic [ROW_W-1:0] i_row,
    input  logic [PIX_W-1:0] i_blue,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_red,
    input  t_cfg             i_cfg,
    output logic             o_hit_vld,
    output logic [COL_W-1:0] o_hit_col,
    output logic [ROW_W-1:0] o_hit_row,
    output logic             o_busy
);

    // stage 0: window, max/min and hue numerator
    logic [PIX_W-1:0]  vmax, vmin, diff;
    logic signed [11:0] hnum;
    logic               in_win;

    always_comb begin
        vmax = i_blue;
        vmin = i_blue;
        if (i_green > vmax) vmax = i_green;
        if (i_red > vmax) vmax = i_red;
        if (i_green < vmin) vmin = i_green;
        if (i_red < vmin) vmin = i_red;
        diff = vmax - vmin;
        if (vmax == i_red) begin
            hnum = $signed({4'b0, i_green}) - $signed({4'b0, i_blue});
        end else if (vmax == i_green) begin
            hnum = $signed({4'b0, i_blue}) - $signed({4'b0, i_red})
                 + $signed({3'b0, diff, 1'b0});
        end else begin
            hnum = $signed({4'b0, i_red}) - $signed({4'b0, i_green})
                 + $signed({2'b0, diff, 2'b0});
        end
        in_win = (i_col >= i_cfg.crop_left)
              && ({2'b0, i_col} < ({2'b0, i_cfg.crop_left} + {1'b0, i_cfg.crop_width}))
              && ({1'b0, i_row} < i_cfg.crop_rows);
    end

    logic               r_vld1, r_vld2, r_vld3, r_hit;
    logic [PIX_W-1:0]   r_v1, r_d1, r_d2, r_v2, r_v3;
    logic signed [11:0] r_h1, r_h2;
    logic [COL_W-1:0]   r_c1, r_c2, r_c3, r_hc;
    logic [ROW_W-1:0]   r_r1, r_r2, r_r3, r_hr;
    logic [RS_W-1:0]    r_rs2;
    logic [RH_W-1:0]    r_rh2;
    logic [27:0]        r_sp3;
    logic signed [29:0] r_hp3;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld1 <= i_vld && in_win;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    // stages 1..3 payload: table lookups, then multiplies
    always_ff @(posedge i_clk) begin
        r_v1  <= vmax;
        r_d1  <= diff;
        r_h1  <= hnum;
        r_c1  <= i_col;
        r_r1  <= i_row;
        r_rs2 <= RECIP_SAT[r_v1];
        r_rh2 <= RECIP_HUE[r_d1];
        r_v2  <= r_v1;
        r_d2  <= r_d1;
        r_h2  <= r_h1;
        r_c2  <= r_c1;
        r_r2  <= r_r1;
        r_sp3 <= {20'b0, r_d2} * {8'b0, r_rs2};
        r_hp3 <= 30'(r_h2 * $signed({1'b0, r_rh2}));
        r_v3  <= r_v2;
        r_c3  <= r_c2;
        r_r3  <= r_r2;
    end

    // stage 3: rounding and red test
    logic [28:0]        s_sum;
    logic [16:0]        sat;
    logic [30:0]        h_sum;
    logic [11:0]        h_raw;
    logic signed [11:0] h_sig;
    logic [7:0]         hue;
    logic               is_red;

    always_comb begin
        s_sum = {1'b0, r_sp3} + 29'd2048;
        sat   = s_sum[28:12];
        h_sum = 31'($signed({r_hp3[29], r_hp3}) + 31'sd4196352);
        h_raw = h_sum[23:12] - 12'd1024;
        h_sig = $signed(h_raw);
        if (h_sig < 0) begin
            hue = h_raw[7:0] + HUE_WRAP;
        end else begin
            hue = h_raw[7:0];
        end
        is_red = (sat >= SAT_LO) && (sat <= SAT_HI)
              && (r_v3 >= VAL_LO) && (r_v3 <= VAL_HI)
              && (((hue >= HUE1_LO) && (hue <= HUE1_HI))
               || ((hue >= HUE2_LO) && (hue <= HUE2_HI)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= r_vld3 && is_red;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hc <= r_c3;
        r_hr <= r_r3;
    end

    assign o_hit_vld = r_hit;
    assign o_hit_col = r_hc;
    assign o_hit_row = r_hr;
    assign o_busy    = r_vld1 | r_vld2 | r_vld3 | r_hit;

endmodule

// ----- src/ldcr_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle: 60 iterations, then o_done is raised.
// Depends on ldcr_pkg for widths.
module ldcr_div import ldcr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DEN_W-1:0] i_dvs,
    output logic [DVD_W-1:0] o_quo,
    output logic             o_done
);

    logic              r_busy, r_done;
    logic [ITER_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem, r_dvs;
    logic [DVD_W-1:0]  r_q;

    logic [DEN_W:0] rem_sh, rem_sub;
    logic           ge;

    always_comb begin
        rem_sh  = {r_rem, r_q[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        ge      = rem_sh >= {1'b0, r_dvs};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ITER_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dvd;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], ge};
        end
    end

    assign o_quo  = r_q;
    assign o_done = r_done;

endmodule

// ----- src/ldcr_dp.sv -----
// Datapath: accumulators, centroid and range arithmetic, output register.
// Depends on ldcr_pkg and instantiates ldcr_div.
module ldcr_dp import ldcr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_cfg              i_cfg,
    input  logic              i_hit_vld,
    input  logic [COL_W-1:0]  i_hit_col,
    input  logic [ROW_W-1:0]  i_hit_row,
    input  logic              i_m_tready,
    output logic              o_div_done,
    output logic              o_found,
    output logic              o_den_zero,
    output logic              o_out_free,
    output logic              o_m_tvalid,
    output logic              o_found_out,
    output logic              o_range_ok,
    output logic [COL_W-1:0]  o_cent_col,
    output logic [ROW_W-1:0]  o_cent_row,
    output logic [COEF_W-1:0] o_range
);

    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_col_sum, r_row_sum;

    // accumulate matched pixels, cleared when the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_col_sum <= '0;
            r_row_sum <= '0;
        end else if (i_cmd.out_load) begin
            r_count   <= '0;
            r_col_sum <= '0;
            r_row_sum <= '0;
        end else if (i_hit_vld && (r_count != COUNT_MAX)) begin
            r_count   <= r_count + 1'b1;
            r_col_sum <= r_col_sum + SUM_W'(i_hit_col);
            r_row_sum <= r_row_sum + SUM_W'(i_hit_row);
        end
    end

    logic [COL_W-1:0]         r_cc;
    logic [ROW_W-1:0]         r_cr;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [NUM_W-1:0]  r_num;
    logic signed [DEN_W-1:0]  r_den;
    logic [DVD_W-1:0]         r_rq;
    t_div_sel                 r_sel;

    // divider operand select
    logic [DVD_W-1:0] dvd, n_ext, n_mag;
    logic [DEN_W-1:0] dvs, d_mag;
    logic [DVD_W-1:0] quo;
    logic             div_done;

    always_comb begin
        n_ext = {r_num, 16'b0};
        n_mag = n_ext[DVD_W-1] ? (~n_ext + 1'b1) : n_ext;
        d_mag = r_den[DEN_W-1] ? DEN_W'(-r_den) : DEN_W'(r_den);
        unique case (i_cmd.div_sel)
            DIV_COL: begin
                dvd = DVD_W'(r_col_sum);
                dvs = DEN_W'(r_count);
            end
            DIV_ROW: begin
                dvd = DVD_W'(r_row_sum);
                dvs = DEN_W'(r_count);
            end
            default: begin
                dvd = n_mag;
                dvs = d_mag;
            end
        endcase
    end

    ldcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dvd   (dvd),
        .i_dvs   (dvs),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    // capture quotients and build the range operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_sel <= i_cmd.div_sel;
        end
        if (div_done) begin
            unique case (r_sel)
                DIV_COL: r_cc <= quo[COL_W-1:0];
                DIV_ROW: r_cr <= quo[ROW_W-1:0];
                default: r_rq <= quo;
            endcase
        end
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'($signed(i_cfg.coeff_slope) * $signed({1'b0, r_cr}));
        end
        if (i_cmd.num_en) begin
            r_num <= NUM_W'($signed(i_cfg.coeff_offset)) + NUM_W'(r_prod);
            r_den <= DEN_W'($signed(i_cfg.coeff_shift))
                   + $signed({8'b0, r_cr, 16'b0});
        end
    end

    // sign and saturation of the range quotient
    logic              neg, ok;
    logic [COEF_W-1:0] sat_rv;

    always_comb begin
        neg = r_num[NUM_W-1] ^ r_den[DEN_W-1];
        if (neg) begin
            sat_rv = (r_rq > DVD_W'(33'h080000000)) ? 32'h8000_0000 : (~r_rq[31:0] + 1'b1);
        end else begin
            sat_rv = (|r_rq[DVD_W-1:31]) ? 32'h7FFF_FFFF : r_rq[31:0];
        end
        ok = o_found && !o_den_zero;
    end

    logic              r_ovld, r_ofound, r_ook;
    logic [COL_W-1:0]  r_occ;
    logic [ROW_W-1:0]  r_ocr;
    logic [COEF_W-1:0] r_orv;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovld <= 1'b1;
        end else if (i_m_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ofound <= o_found;
            r_ook    <= ok;
            r_occ    <= o_found ? r_cc : '0;
            r_ocr    <= o_found ? r_cr : '0;
            r_orv    <= ok ? sat_rv : '0;
        end
    end

    assign o_div_done  = div_done;
    assign o_found     = r_count != '0;
    assign o_den_zero  = r_den == '0;
    assign o_out_free  = !r_ovld || i_m_tready;
    assign o_m_tvalid  = r_ovld;
    assign o_found_out = r_ofound;
    assign o_range_ok  = r_ook;
    assign o_cent_col  = r_occ;
    assign o_cent_row  = r_ocr;
    assign o_range     = r_orv;

endmodule

// ----- src/ldcr_ctrl.sv -----
// Controller: accepts pixels, drains the pixel pipeline at frame end and
// sequences the divisions and range arithmetic. Depends on ldcr_pkg.
module ldcr_ctrl import ldcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  logic i_s_tlast,
    input  t_sts i_sts,
    output logic o_s_tready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_s_tvalid && i_s_tlast) n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = i_sts.found ? ST_DIV_COL : ST_OUT;
                end
            end
            ST_DIV_COL:  n_state = ST_WAIT_COL;
            ST_WAIT_COL: if (i_sts.div_done) n_state = ST_DIV_ROW;
            ST_DIV_ROW:  n_state = ST_WAIT_ROW;
            ST_WAIT_ROW: if (i_sts.div_done) n_state = ST_MUL;
            ST_MUL:      n_state = ST_NUM;
            ST_NUM:      n_state = ST_CHK;
            ST_CHK:      n_state = i_sts.den_zero ? ST_OUT : ST_DIV_RNG;
            ST_DIV_RNG:  n_state = ST_WAIT_RNG;
            ST_WAIT_RNG: if (i_sts.div_done) n_state = ST_OUT;
            ST_OUT:      if (i_sts.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready     = 1'b0;
        o_cmd          = '0;
        o_cmd.div_sel  = DIV_COL;
        unique case (r_state)
            ST_IDLE:    o_s_tready = 1'b1;
            ST_DIV_COL: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_COL;
            end
            ST_DIV_ROW: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_ROW;
            end
            ST_MUL:     o_cmd.mul_en = 1'b1;
            ST_NUM:     o_cmd.num_en = 1'b1;
            ST_DIV_RNG: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_RNG;
            end
            ST_OUT:     o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// ----- src/laser_dot_centroid_ranger.sv -----
// Laser dot centroid ranger: top level with configuration registers.
// Instantiates ldcr_pix, ldcr_ctrl and ldcr_dp; depends on ldcr_pkg.
//
// Usage:
//   Pixels arrive on the s_axis channel, one item per pixel, with tlast on the
//   last pixel of a frame. A pixel is taken in every cycle while no frame end
//   is being processed: within a frame the rate is one item per clock.
//   The item carrying tlast starts the frame-end sequence: the four-stage pixel
//   pipeline drains, then the shared serial divider runs for the column mean,
//   the row mean and, if the denominator is nonzero, the range quotient, with
//   the multiply, numerator and check steps between the last two. A frame with
//   no red pixel goes straight from the drain to loading its result.
//   s_axis_tready is low from the tlast item until the result is loaded.
//   One result item per frame leaves on m_axis from an output register. A
//   waiting result does not block new pixels; a second frame end waits in its
//   last step until the receiver has taken the previous result.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) are taken in any
//   cycle and belong between frames. Reset restores the register defaults,
//   clears the accumulators and empties the pipeline and output register.
module laser_dot_centroid_ranger import ldcr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // column[9:0], row[19:10], blue[27:20], green[35:28], red[43:36], zero pad
    input  logic [47:0]          s_axis_tdata,
    // frame_end
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // centroid_col[9:0], centroid_row[19:10], range_value[51:20], zero pad
    output logic [55:0]          m_axis_tdata,
    // found[0], range_ok[1]
    output logic [1:0]           m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    t_cfg r_cfg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crop_left    <= LEFT_W'(224);
            r_cfg.crop_width   <= CROP_W'(192);
            r_cfg.crop_rows    <= CROP_W'(479);
            r_cfg.coeff_offset <= '0;
            r_cfg.coeff_slope  <= '0;
            r_cfg.coeff_shift  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CROP_LEFT:    r_cfg.crop_left    <= i_cfg_data[LEFT_W-1:0];
                REG_CROP_WIDTH:   r_cfg.crop_width   <= i_cfg_data[CROP_W-1:0];
                REG_CROP_ROWS:    r_cfg.crop_rows    <= i_cfg_data[CROP_W-1:0];
                REG_COEFF_OFFSET: r_cfg.coeff_offset <= i_cfg_data;
                REG_COEFF_SLOPE:  r_cfg.coeff_slope  <= i_cfg_data;
                REG_COEFF_SHIFT:  r_cfg.coeff_shift  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_cmd             cmd;
    t_sts             sts;
    logic             pix_acc;
    logic             hit_vld, pipe_busy;
    logic [COL_W-1:0] hit_col, cent_col;
    logic [ROW_W-1:0] hit_row, cent_row;
    logic [COEF_W-1:0] range_val;
    logic             div_done, found, den_zero, out_free, found_out, range_ok;

    assign pix_acc = s_axis_tvalid && s_axis_tready;

    ldcr_pix u_pix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (pix_acc),
        .i_col     (s_axis_tdata[9:0]),
        .i_row     (s_axis_tdata[19:10]),
        .i_blue    (s_axis_tdata[27:20]),
        .i_green   (s_axis_tdata[35:28]),
        .i_red     (s_axis_tdata[43:36]),
        .i_cfg     (r_cfg),
        .o_hit_vld (hit_vld),
        .o_hit_col (hit_col),
        .o_hit_row (hit_row),
        .o_busy    (pipe_busy)
    );

    always_comb begin
        sts.pipe_busy = pipe_busy;
        sts.div_done  = div_done;
        sts.found     = found;
        sts.den_zero  = den_zero;
        sts.out_free  = out_free;
    end

    ldcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .i_sts      (sts),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd)
    );

    ldcr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (r_cfg),
        .i_hit_vld   (hit_vld),
        .i_hit_col   (hit_col),
        .i_hit_row   (hit_row),
        .i_m_tready  (m_axis_tready),
        .o_div_done  (div_done),
        .o_found     (found),
        .o_den_zero  (den_zero),
        .o_out_free  (out_free),
        .o_m_tvalid  (m_axis_tvalid),
        .o_found_out (found_out),
        .o_range_ok  (range_ok),
        .o_cent_col  (cent_col),
        .o_cent_row  (cent_row),
        .o_range     (range_val)
    );

    assign m_axis_tdata = {4'b0, range_val, cent_row, cent_col};
    assign m_axis_tuser = {range_ok, found_out};

    // a range is only reported for a frame with a match
    a_ok_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[1] && !m_axis_tuser[0]))
        else $error("range_ok without found");

    // an empty frame reports all-zero data
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("nonzero data for an empty frame");

    // intake stops after a frame end item
    a_stop_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("pixel intake continued after frame end");

    // results are loaded only with the pixel pipeline empty and intake stopped
    a_load_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!pipe_busy && !s_axis_tready))
        else $error("result loaded while pixels in flight");

endmodule

// ----- bench/laser_dot_centroid_ranger_tb.sv -----
// Testbench for the laser dot centroid ranger: directed and random frames, HSV/centroid predictor.
// Depends on ldcr_pkg and the laser_dot_centroid_ranger top level.
module laser_dot_centroid_ranger_tb import ldcr_pkg::*; ;

    typedef struct {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] b, g, r;
        logic             fe;
    } t_pix;

    typedef struct {
        logic              found;
        logic [COL_W-1:0]  cc;
        logic [ROW_W-1:0]  cr;
        logic [COEF_W-1:0] rv;
        logic              ok;
    } t_spot;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [55:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0]    i_cfg_data;

    t_pix  pixel_q[$];
    t_spot spot_q[$];

    // predictor copy of registers and accumulators
    int unsigned       win_left, win_width, win_rows;
    logic [COEF_W-1:0] k_off, k_slope, k_shift;
    int unsigned       red_count, col_total, row_total;

    int  errors;
    bit  pix_taken, spot_taken;
    int  send_gap, recv_stall, idle_cycles;
    bit  send_burst, recv_burst;

    laser_dot_centroid_ranger dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // round((num << 12) / d)
    function automatic int unsigned recip(int unsigned num, int unsigned d);
        if (d == 0) return 0;
        return (2 * (num << 12) + d) / (2 * d);
    endfunction

    function automatic bit red_pixel(int unsigned b, int unsigned g, int unsigned r);
        int unsigned v, mn, diff, s;
        int h, prod;
        v = b; mn = b;
        if (g > v) v = g;
        if (r > v) v = r;
        if (g < mn) mn = g;
        if (r < mn) mn = r;
        diff = v - mn;
        s = (diff * recip(255, v) + 2048) >> 12;
        if (v == r) h = int'(g) - int'(b);
        else if (v == g) h = int'(b) - int'(r) + 2 * int'(diff);
        else h = int'(r) - int'(g) + 4 * int'(diff);
        prod = h * int'(recip(30, diff));
        h = ((prod + 2048 + (1024 << 12)) >>> 12) - 1024;
        if (h < 0) h += 180;
        if (s < 50 || s > 250 || v < 50 || v > 250) return 1'b0;
        return (h >= 1 && h <= 15) || (h >= 165 && h <= 179);
    endfunction

    // accumulate one pixel; on frame end queue the expected spot
    task automatic predict_pixel(t_pix p);
        t_spot  e;
        longint num, den, q;
        if (p.col >= win_left && p.col < win_left + win_width && p.row < win_rows &&
            red_count < 32'hFFFFF && red_pixel(p.b, p.g, p.r)) begin
            red_count++;
            col_total += p.col;
            row_total += p.row;
        end
        if (p.fe) begin
            e = '{1'b0, '0, '0, '0, 1'b0};
            if (red_count != 0) begin
                e.found = 1'b1;
                e.cc = COL_W'(col_total / red_count);
                e.cr = ROW_W'(row_total / red_count);
                num = longint'(signed'(k_off)) + longint'(signed'(k_slope)) * longint'(e.cr);
                den = longint'(signed'(k_shift)) + longint'(e.cr) * 65536;
                if (den != 0) begin
                    q = (num * 65536) / den;
                    if (q > 64'sd2147483647) q = 64'sd2147483647;
                    if (q < -64'sd2147483648) q = -64'sd2147483648;
                    e.rv = q[31:0];
                    e.ok = 1'b1;
                end
            end
            spot_q.push_back(e);
            red_count = 0; col_total = 0; row_total = 0;
        end
    endtask

    function automatic t_pix mk_pix(int c, int rw, int b, int g, int r, bit fe);
        t_pix p;
        p.col = COL_W'(c); p.row = ROW_W'(rw);
        p.b = PIX_W'(b); p.g = PIX_W'(g); p.r = PIX_W'(r); p.fe = fe;
        return p;
    endfunction

    // reddish pixel inside the current window most of the time
    function automatic t_pix rand_pix(bit fe);
        t_pix p;
        int r;
        if ($urandom_range(0, 4) == 0) begin
            p = mk_pix($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255), fe);
        end else begin
            r = $urandom_range(40, 255);
            p = mk_pix(win_left + $urandom_range(0, win_width - 1),
                       $urandom_range(0, win_rows - 1), $urandom_range(0, r / 3),
                       $urandom_range(0, r / 3), r, fe);
        end
        return p;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [COEF_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_CROP_LEFT:    win_left  = val[LEFT_W-1:0];
            REG_CROP_WIDTH:   win_width = val[CROP_W-1:0];
            REG_CROP_ROWS:    win_rows  = val[CROP_W-1:0];
            REG_COEFF_OFFSET: k_off     = val;
            REG_COEFF_SLOPE:  k_slope   = val;
            REG_COEFF_SHIFT:  k_shift   = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (spot_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_frames(int n_items);
        int n, len;
        n = 0;
        while (n < n_items) begin
            len = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(2, 40);
            for (int i = 0; i < len; i++) pixel_q.push_back(rand_pix(i == len - 1));
            n += len;
        end
    endtask

    // sender: pops pending items, random gaps
    always @(negedge i_clk) begin
        logic vld;
        t_pix p;
        vld = s_axis_tvalid;
        if (!i_rst_n) begin
            vld = 1'b0;
        end else if (s_axis_tvalid && !pix_taken) begin
            vld = 1'b1;
        end else if (send_gap > 0) begin
            send_gap--;
            vld = 1'b0;
        end else if (pixel_q.size() != 0) begin
            p = pixel_q.pop_front();
            s_axis_tdata <= {4'b0, p.r, p.g, p.b, p.row, p.col};
            s_axis_tlast <= p.fe;
            vld = 1'b1;
            if ($urandom_range(0, 99) == 0) send_burst = ~send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 8);
        end else begin
            vld = 1'b0;
        end
        s_axis_tvalid <= vld;
        pix_taken = 1'b0;
    end

    // receiver: random stalls
    always @(negedge i_clk) begin
        if (spot_taken || !m_axis_tready) begin
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) == 0) recv_burst = ~recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 8);
            end
        end
        spot_taken = 1'b0;
    end

    // monitor: predict on accepted pixels, check accepted spots
    always @(posedge i_clk) begin
        t_pix  p;
        t_spot e;
        if (i_rst_n) begin
            idle_cycles++;
            if (s_axis_tvalid && s_axis_tready) begin
                pix_taken = 1'b1;
                idle_cycles = 0;
                p = mk_pix(s_axis_tdata[9:0], s_axis_tdata[19:10], s_axis_tdata[27:20],
                           s_axis_tdata[35:28], s_axis_tdata[43:36], s_axis_tlast);
                predict_pixel(p);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                spot_taken = 1'b1;
                idle_cycles = 0;
                if (spot_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result tdata=%h tuser=%b", $time,
                             m_axis_tdata, m_axis_tuser);
                end else begin
                    e = spot_q.pop_front();
                    if (m_axis_tuser[0] !== e.found || m_axis_tdata[9:0] !== e.cc ||
                        m_axis_tdata[19:10] !== e.cr || m_axis_tdata[51:20] !== e.rv ||
                        m_axis_tuser[1] !== e.ok) begin
                        errors++;
                        $display("%0t: mismatch exp found=%b col=%0d row=%0d range=%h ok=%b",
                                 $time, e.found, e.cc, e.cr, e.rv, e.ok);
                        $display("%0t:          got found=%b col=%0d row=%0d range=%h ok=%b",
                                 $time, m_axis_tuser[0], m_axis_tdata[9:0],
                                 m_axis_tdata[19:10], m_axis_tdata[51:20], m_axis_tuser[1]);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout", $time);
                $display("** laser_dot_centroid_ranger: FAILED **");
                $finish;
            end
        end
    end

    // stimulus and phases
    initial begin
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = REG_CROP_LEFT; i_cfg_data = '0;
        errors = 0; send_gap = 0; recv_stall = 0; idle_cycles = 0;
        send_burst = 1'b0; recv_burst = 1'b0;
        win_left = 224; win_width = 192; win_rows = 479;
        k_off = '0; k_slope = '0; k_shift = '0;
        red_count = 0; col_total = 0; row_total = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset window: zero denominator (red at row 0), no red, extremes
        pixel_q.push_back(mk_pix(300, 0, 10, 20, 200, 1));
        pixel_q.push_back(mk_pix(300, 10, 128, 128, 128, 1));
        pixel_q.push_back(mk_pix(0, 0, 0, 0, 0, 0));
        pixel_q.push_back(mk_pix(1023, 1023, 255, 255, 255, 0));
        pixel_q.push_back(mk_pix(224, 478, 20, 10, 200, 0));
        pixel_q.push_back(mk_pix(415, 100, 10, 20, 200, 0));
        pixel_q.push_back(mk_pix(416, 100, 10, 20, 200, 0));
        pixel_q.push_back(mk_pix(223, 100, 10, 20, 200, 0));
        pixel_q.push_back(mk_pix(300, 479, 10, 20, 200, 1));
        pixel_q.push_back(mk_pix(300, 50, 0, 255, 255, 0));
        pixel_q.push_back(mk_pix(300, 60, 255, 0, 255, 0));
        pixel_q.push_back(mk_pix(300, 70, 255, 0, 0, 0));
        pixel_q.push_back(mk_pix(300, 80, 40, 30, 250, 0));
        pixel_q.push_back(mk_pix(300, 90, 30, 40, 251, 0));
        pixel_q.push_back(mk_pix(300, 95, 49, 45, 49, 1));
        wait_idle();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_CROP_LEFT, 0); write_reg(REG_CROP_WIDTH, 1024);
                    write_reg(REG_CROP_ROWS, 1024);
                    write_reg(REG_COEFF_OFFSET, 32'h7FFFFFFF);
                    write_reg(REG_COEFF_SLOPE, 32'h7FFFFFFF);
                    write_reg(REG_COEFF_SHIFT, 32'h00000001);
                end
                1: begin
                    write_reg(REG_CROP_LEFT, 1023); write_reg(REG_CROP_WIDTH, 1024);
                    write_reg(REG_CROP_ROWS, 1);
                    write_reg(REG_COEFF_OFFSET, 32'h80000000);
                    write_reg(REG_COEFF_SLOPE, 32'h80000000);
                    write_reg(REG_COEFF_SHIFT, 32'h80000000);
                end
                2: begin
                    write_reg(REG_CROP_LEFT, 512); write_reg(REG_CROP_WIDTH, 1);
                    write_reg(REG_CROP_ROWS, 1024);
                    write_reg(REG_COEFF_SHIFT, 32'hFFFF0000);
                end
                default: begin
                    write_reg(REG_CROP_LEFT, $urandom_range(0, 900));
                    write_reg(REG_CROP_WIDTH, $urandom_range(1, 1024));
                    write_reg(REG_CROP_ROWS, $urandom_range(1, 1024));
                    write_reg(REG_COEFF_OFFSET, $urandom);
                    write_reg(REG_COEFF_SLOPE, $urandom);
                    write_reg(REG_COEFF_SHIFT, $urandom_range(0, 1) ? $urandom
                                                                    : -(win_rows * 32768));
                end
            endcase
            random_frames(ph < 3 ? 150 : 400);
            wait_idle();
        end

        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("** laser_dot_centroid_ranger: PASSED **");
        end else begin
            $display("** laser_dot_centroid_ranger: FAILED **");
        end
        $finish;
    end

endmodule
